// ===== sv/tsrgm_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-source ramped gain mixer package
// Widths, reset values, register map, request types and sequencer states.
// ----------------------------------------------------------------------------
package tsrgm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 5;
    localparam int RAMP_EXTRA     = 12;
    localparam int RAMP_W         = GAIN_W + RAMP_EXTRA;
    localparam int STEP_W         = RAMP_W + 1;
    localparam int MAX_BLOCK_DEF  = 4096;
    localparam int BF_W           = 13;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;
    localparam int NSRC           = 2;
    localparam int SRC_INS        = 0;
    localparam int SRC_VOC        = 1;

    localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(16 << GAIN_FRAC_BITS);
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);
    localparam logic [BF_W-1:0]   BF_RESET = BF_W'(256);
    localparam logic [RAMP_W-1:0] RAMP_MAX = {GAIN_MAX, {RAMP_EXTRA{1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] instrument_sample;
        logic signed [SAMPLE_BITS-1:0] voice_sample;
    } sample_req_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          block_end;
    } mix_req_t;

    typedef enum logic [2:0] {
        REG_INS_EN       = 3'd0,
        REG_VOC_EN       = 3'd1,
        REG_INS_GAIN     = 3'd2,
        REG_VOC_GAIN     = 3'd3,
        REG_BLOCK_FRAMES = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STEP,
        ST_RAMP,
        ST_MUL,
        ST_FINISH
    } state_t;

endpackage

// ===== sv/two_source_ramped_gain_mixer.sv =====
// ----------------------------------------------------------------------------
// Two-source ramped gain mixer
// Mixes instrument and voice samples under per-block linear gain ramps.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: one request carries an instrument and a voice sample.
//   mix channel: one request per sample request, left = right = saturated mix,
//   block_end marks the last frame of a block.
//   APB port: enables, target gains (clamped to 16.0) and block length.
//   Write configuration only while the block is idle.
// Sequence:
//   A frame is accepted, passes the ramp update and the bit-serial shift-add
//   multiplier (Q5.16 gains) that walks one gain bit per cycle, and is loaded
//   into the output register; no new sample is taken before that load. The
//   first frame of a block first runs the restoring divider that forms the
//   ramp step, one quotient bit per cycle for both sources in parallel.
// Reset: configuration returns to its defaults, gains and ramps clear to zero,
//   frame position returns to the block start. No clearing pass.
// Stall: a finished result waits in the output register; the next sample is
//   accepted and processed, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module two_source_ramped_gain_mixer #(
    parameter int MAX_BLOCK = tsrgm_pkg::MAX_BLOCK_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsrgm_pkg::ADDR_W-1:0]   paddr,
    input  logic [tsrgm_pkg::DATA_W-1:0]   pwdata,
    output logic [tsrgm_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  tsrgm_pkg::sample_req_t         sample_data,
    output logic                           mix_valid,
    input  logic                           mix_ready,
    output tsrgm_pkg::mix_req_t            mix_data
);
    import tsrgm_pkg::*;

    localparam int LEN_W = $clog2(MAX_BLOCK + 1);
    localparam int LW    = (LEN_W > BF_W) ? LEN_W : BF_W;
    localparam int FI_W  = $clog2(MAX_BLOCK);
    localparam int DIV_W = RAMP_W;
    localparam int CNT_W = $clog2(DIV_W);
    localparam int SUM_W = SAMPLE_BITS + 2;
    localparam int ACC_W = SUM_W + GAIN_W;
    localparam int HI_W  = ACC_W - GAIN_FRAC_BITS - SAMPLE_BITS + 1;

    localparam logic [LW-1:0]          MAX_LEN  = LW'(MAX_BLOCK);
    localparam logic [ACC_W-1:0]       ACC_INIT = ACC_W'(1) << (GAIN_W + GAIN_FRAC_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // configuration
    cfg_reg_t                  cfg_idx;
    logic                      cfg_wr;
    logic [GAIN_W-1:0]         gain_wr;
    logic                      en_reg      [NSRC];
    logic [GAIN_W-1:0]         gain_reg    [NSRC];
    logic [BF_W-1:0]           bf_reg;

    // sequencer
    state_t                    state_reg;
    state_t                    state_next;
    logic                      accept;
    logic                      load_out;
    logic [CNT_W-1:0]          cnt_reg;

    // block and ramp state
    logic [FI_W-1:0]           frame_idx_reg;
    logic [GAIN_W-1:0]         settled_reg [NSRC];
    logic [GAIN_W-1:0]         target_reg  [NSRC];
    logic [RAMP_W-1:0]         ramp_reg    [NSRC];
    logic signed [STEP_W-1:0]  step_reg    [NSRC];

    // datapath
    sample_req_t               smp_reg;
    logic                      last_reg;
    logic [LW-1:0]             len_reg;
    logic                      neg_reg     [NSRC];
    logic [LW-1:0]             rem_reg     [NSRC];
    logic [DIV_W-1:0]          quo_reg     [NSRC];
    logic [GAIN_W-1:0]         gsh_reg     [NSRC];
    logic [ACC_W-1:0]          acc_reg;
    mix_req_t                  mix_reg;
    logic                      mix_valid_reg;

    logic [LW-1:0]             len_eff;
    logic                      last_now;
    logic [GAIN_W-1:0]         tgt_now     [NSRC];
    logic signed [GAIN_W:0]    diff        [NSRC];
    logic signed [GAIN_W:0]    diff_neg    [NSRC];
    logic [GAIN_W-1:0]         mag         [NSRC];
    logic [LW:0]               rem_sh      [NSRC];
    logic                      rem_ge      [NSRC];
    logic [LW:0]               rem_sub     [NSRC];
    logic [LW-1:0]             rem_next    [NSRC];
    logic [DIV_W-1:0]          quo_next    [NSRC];
    logic signed [STEP_W-1:0]  quo_pos     [NSRC];
    logic signed [STEP_W-1:0]  step_next   [NSRC];
    logic signed [RAMP_W+1:0]  ramp_sum    [NSRC];
    logic [RAMP_W-1:0]         ramp_next   [NSRC];
    logic signed [SUM_W-1:0]   acc_upper;
    logic signed [SAMPLE_BITS-1:0] prod_ins;
    logic signed [SAMPLE_BITS-1:0] prod_voc;
    logic signed [SUM_W-1:0]   psum;
    logic [ACC_W-1:0]          acc_next;
    logic [HI_W-1:0]           res_hi;
    logic [SAMPLE_BITS-1:0]    mix_val;

    // ------------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = cfg_reg_t'(paddr[ADDR_W-1:2]);
    assign gain_wr = (pwdata[GAIN_W-1:0] > GAIN_MAX) ? GAIN_MAX : pwdata[GAIN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg[SRC_INS]   <= 1'b0;
            en_reg[SRC_VOC]   <= 1'b0;
            gain_reg[SRC_INS] <= GAIN_ONE;
            gain_reg[SRC_VOC] <= GAIN_ONE;
            bf_reg            <= BF_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_INS_EN:       en_reg[SRC_INS]   <= pwdata[0];
                REG_VOC_EN:       en_reg[SRC_VOC]   <= pwdata[0];
                REG_INS_GAIN:     gain_reg[SRC_INS] <= gain_wr;
                REG_VOC_GAIN:     gain_reg[SRC_VOC] <= gain_wr;
                REG_BLOCK_FRAMES: bf_reg            <= pwdata[BF_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_INS_EN:       prdata = DATA_W'(en_reg[SRC_INS]);
            REG_VOC_EN:       prdata = DATA_W'(en_reg[SRC_VOC]);
            REG_INS_GAIN:     prdata = DATA_W'(gain_reg[SRC_INS]);
            REG_VOC_GAIN:     prdata = DATA_W'(gain_reg[SRC_VOC]);
            REG_BLOCK_FRAMES: prdata = DATA_W'(bf_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    accept     = 1'b1;
                    state_next = (frame_idx_reg == '0) ? ST_DIV : ST_RAMP;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = ST_RAMP;
            end
            ST_RAMP:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == CNT_W'(GAIN_W - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!mix_valid_reg || mix_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign sample_ready = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------------
    // Block length, step divider, ramp
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (bf_reg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (LW'(bf_reg) > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = LW'(bf_reg);
        end
        last_now = ({1'b0, LW'(frame_idx_reg)} + (LW+1)'(1)) >= {1'b0, len_eff};
    end

    always_comb
    begin
        for (int i = 0; i < NSRC; i++)
        begin
            tgt_now[i]   = en_reg[i] ? gain_reg[i] : '0;
            diff[i]      = $signed({1'b0, tgt_now[i]}) - $signed({1'b0, settled_reg[i]});
            diff_neg[i]  = -diff[i];
            mag[i]       = diff[i][GAIN_W] ? diff_neg[i][GAIN_W-1:0] : diff[i][GAIN_W-1:0];

            // restoring division, one quotient bit per cycle
            rem_sh[i]    = {rem_reg[i], quo_reg[i][DIV_W-1]};
            rem_ge[i]    = rem_sh[i] >= {1'b0, len_reg};
            rem_sub[i]   = rem_sh[i] - {1'b0, len_reg};
            rem_next[i]  = rem_ge[i] ? rem_sub[i][LW-1:0] : rem_sh[i][LW-1:0];
            quo_next[i]  = {quo_reg[i][DIV_W-2:0], rem_ge[i]};
            quo_pos[i]   = $signed({1'b0, quo_reg[i]});
            step_next[i] = neg_reg[i] ? -quo_pos[i] : quo_pos[i];

            ramp_sum[i]  = $signed({2'b00, ramp_reg[i]})
                         + $signed({step_reg[i][STEP_W-1], step_reg[i]});
            if (last_reg)
            begin
                ramp_next[i] = {target_reg[i], {RAMP_EXTRA{1'b0}}};
            end
            else if (ramp_sum[i][RAMP_W+1])
            begin
                ramp_next[i] = '0;
            end
            else if (ramp_sum[i] > $signed({2'b00, RAMP_MAX}))
            begin
                ramp_next[i] = RAMP_MAX;
            end
            else
            begin
                ramp_next[i] = ramp_sum[i][RAMP_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Bit-serial multiply-accumulate and output saturation
    // ------------------------------------------------------------------------
    always_comb
    begin
        acc_upper = $signed(acc_reg[ACC_W-1:GAIN_W]);
        prod_ins  = gsh_reg[SRC_INS][0] ? smp_reg.instrument_sample : '0;
        prod_voc  = gsh_reg[SRC_VOC][0] ? smp_reg.voice_sample : '0;
        psum      = acc_upper
                  + $signed({{2{prod_ins[SAMPLE_BITS-1]}}, prod_ins})
                  + $signed({{2{prod_voc[SAMPLE_BITS-1]}}, prod_voc});
        acc_next  = {psum[SUM_W-1], psum, acc_reg[GAIN_W-1:1]};

        res_hi    = acc_reg[ACC_W-1:GAIN_FRAC_BITS+SAMPLE_BITS-1];
        if ((&res_hi) | ~(|res_hi))
        begin
            mix_val = acc_reg[GAIN_FRAC_BITS+SAMPLE_BITS-1:GAIN_FRAC_BITS];
        end
        else
        begin
            mix_val = acc_reg[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    // ------------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            frame_idx_reg <= '0;
            for (int i = 0; i < NSRC; i++)
            begin
                settled_reg[i] <= '0;
                target_reg[i]  <= '0;
                ramp_reg[i]    <= '0;
                step_reg[i]    <= '0;
            end
        end
        else
        begin
            if (load_out)
            begin
                mix_valid_reg <= 1'b1;
            end
            else if (mix_ready)
            begin
                mix_valid_reg <= 1'b0;
            end

            if (accept || state_reg == ST_RAMP)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV || state_reg == ST_MUL)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (accept && frame_idx_reg == '0)
            begin
                for (int i = 0; i < NSRC; i++)
                begin
                    target_reg[i] <= tgt_now[i];
                    ramp_reg[i]   <= {settled_reg[i], {RAMP_EXTRA{1'b0}}};
                end
            end

            if (state_reg == ST_STEP)
            begin
                for (int i = 0; i < NSRC; i++)
                begin
                    step_reg[i] <= step_next[i];
                end
            end

            if (state_reg == ST_RAMP)
            begin
                for (int i = 0; i < NSRC; i++)
                begin
                    ramp_reg[i] <= ramp_next[i];
                    if (last_reg)
                    begin
                        settled_reg[i] <= target_reg[i];
                    end
                end
                if (last_reg)
                begin
                    frame_idx_reg <= '0;
                end
                else
                begin
                    frame_idx_reg <= frame_idx_reg + FI_W'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_reg  <= sample_data;
            last_reg <= last_now;
            len_reg  <= len_eff;
            for (int i = 0; i < NSRC; i++)
            begin
                neg_reg[i] <= diff[i][GAIN_W];
                quo_reg[i] <= {mag[i], {RAMP_EXTRA{1'b0}}};
                rem_reg[i] <= '0;
            end
        end

        if (state_reg == ST_DIV)
        begin
            for (int i = 0; i < NSRC; i++)
            begin
                quo_reg[i] <= quo_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end

        if (state_reg == ST_RAMP)
        begin
            for (int i = 0; i < NSRC; i++)
            begin
                gsh_reg[i] <= ramp_next[i][RAMP_W-1:RAMP_EXTRA];
            end
            acc_reg <= ACC_INIT;    // rounding half folded in up front
        end

        if (state_reg == ST_MUL)
        begin
            for (int i = 0; i < NSRC; i++)
            begin
                gsh_reg[i] <= gsh_reg[i] >> 1;
            end
            acc_reg <= acc_next;
        end

        if (load_out)
        begin
            mix_reg.left_sample  <= mix_val;
            mix_reg.right_sample <= mix_val;
            mix_reg.block_end    <= last_reg;
        end
    end

    assign mix_valid = mix_valid_reg;
    assign mix_data  = mix_reg;

`ifndef NO_ASSERTIONS
    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(frame_idx_reg) < MAX_LEN)
        else $error("frame index beyond block length limit");

    a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ramp_reg[SRC_INS] <= RAMP_MAX) && (ramp_reg[SRC_VOC] <= RAMP_MAX))
        else $error("ramp gain outside 0..16.0");

    a_div_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (frame_idx_reg == '0))
        else $error("step division outside block start");

    a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (mix_data.block_end == (frame_idx_reg == '0)))
        else $error("block_end disagrees with frame position");
`endif

endmodule

// ===== bench/two_source_ramped_gain_mixer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-source ramped gain mixer testbench
// Drives sample requests and APB register writes into the mixer and checks
// every mix request against an in-bench model of the gain ramps, rounding
// and saturation. A short directed part covers saturation, rounding ties,
// register masking and clamping, block length limits, blocks cut short or
// stretched mid-way, and ramp overshoot. It is followed by random phases
// with random register settings, idle gaps on the sample side and stalls on
// the mix side.
// ----------------------------------------------------------------------------
module two_source_ramped_gain_mixer_tb;

    import tsrgm_pkg::*;

    localparam int              RANDOM_FRAMES  = 380;
    localparam int              QUIET_FRAMES   = 60;
    localparam int              WATCHDOG_LIMIT = 2000;
    localparam int              DRAIN_CYCLES   = 80;
    localparam logic [2:0]      REG_SPARE_LO   = 3'd5;
    localparam logic [2:0]      REG_SPARE_HI   = 3'd7;
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam longint          RAMP_TOP = longint'(GAIN_MAX) <<< RAMP_EXTRA;
    localparam longint          MIX_HI   = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint          MIX_LO   = -MIX_HI - 1;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                sample_valid = 1'b0;
    logic                sample_ready;
    sample_req_t         sample_data  = '0;
    logic                mix_valid;
    logic                mix_ready    = 1'b0;
    mix_req_t            mix_data;

    // mixer model state
    bit          src_enable[NSRC];
    longint      gain_setting[NSRC];
    longint      settled_gain[NSRC];
    longint      ramp_gain[NSRC];
    longint      ramp_step[NSRC];
    longint      block_target[NSRC];
    int unsigned frames_setting;
    int unsigned frame_pos;

    mix_req_t    expected_mix[$];
    mix_req_t    oldest_mix;
    bit          idle_on        = 1'b1;
    int          stall_left     = 0;
    int          quiet_cycles   = 0;
    int          mismatch_count = 0;
    int          frames_sent    = 0;
    int          random_sent    = 0;
    int          mixes_checked  = 0;
    int          block_ends     = 0;
    int          reg_writes     = 0;

    two_source_ramped_gain_mixer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .mix_valid    (mix_valid),
        .mix_ready    (mix_ready),
        .mix_data     (mix_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic longint clamp_gain_write(input logic [DATA_W-1:0] v);
        longint g;
        g = longint'(v[GAIN_W-1:0]);
        if (g > longint'(GAIN_MAX))
            g = longint'(GAIN_MAX);
        return g;
    endfunction

    function automatic void apply_setting(input logic [2:0] idx, input logic [DATA_W-1:0] v);
        case (idx)
            REG_INS_EN:       src_enable[SRC_INS] = v[0];
            REG_VOC_EN:       src_enable[SRC_VOC] = v[0];
            REG_INS_GAIN:     gain_setting[SRC_INS] = clamp_gain_write(v);
            REG_VOC_GAIN:     gain_setting[SRC_VOC] = clamp_gain_write(v);
            REG_BLOCK_FRAMES: frames_setting = int'(v[BF_W-1:0]);
            default:          ;
        endcase
    endfunction

    task automatic predict_mix(input sample_req_t s, output mix_req_t m);
        int unsigned len;
        bit          last;
        longint      g[NSRC];
        longint      smp[NSRC];
        longint      acc;
        len = frames_setting;
        if (len == 0)
            len = 1;
        if (len > MAX_BLOCK_DEF)
            len = MAX_BLOCK_DEF;
        smp[SRC_INS] = longint'($signed(s.instrument_sample));
        smp[SRC_VOC] = longint'($signed(s.voice_sample));
        if (frame_pos == 0)
        begin
            for (int i = 0; i < NSRC; i++)
            begin
                block_target[i] = src_enable[i] ? gain_setting[i] : 0;
                ramp_step[i] = ((block_target[i] - settled_gain[i]) * longint'(4096))
                               / longint'(len);
                ramp_gain[i] = settled_gain[i] <<< RAMP_EXTRA;
            end
        end
        last = (frame_pos + 1 >= len);
        for (int i = 0; i < NSRC; i++)
        begin
            if (last)
                ramp_gain[i] = block_target[i] <<< RAMP_EXTRA;
            else
            begin
                ramp_gain[i] = ramp_gain[i] + ramp_step[i];
                if (ramp_gain[i] < 0)
                    ramp_gain[i] = 0;
                if (ramp_gain[i] > RAMP_TOP)
                    ramp_gain[i] = RAMP_TOP;
            end
            g[i] = ramp_gain[i] >>> RAMP_EXTRA;
        end
        acc = smp[SRC_INS] * g[SRC_INS] + smp[SRC_VOC] * g[SRC_VOC];
        acc = (acc + (longint'(1) <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
        if (acc > MIX_HI)
            acc = MIX_HI;
        if (acc < MIX_LO)
            acc = MIX_LO;
        if (last)
        begin
            for (int i = 0; i < NSRC; i++)
                settled_gain[i] = block_target[i];
            frame_pos = 0;
        end
        else
            frame_pos++;
        m.left_sample  = acc[SAMPLE_BITS-1:0];
        m.right_sample = acc[SAMPLE_BITS-1:0];
        m.block_end    = last;
    endtask

    function automatic sample_req_t frame_of(input logic [SAMPLE_BITS-1:0] ins,
                                             input logic [SAMPLE_BITS-1:0] voc);
        sample_req_t s;
        s.instrument_sample = ins;
        s.voice_sample      = voc;
        return s;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return '0;
            3:       return SAMPLE_BITS'($urandom_range(0, 255)) - SAMPLE_BITS'(128);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return DATA_W'(GAIN_MAX);
            2:       return $urandom();
            3:       return DATA_W'(GAIN_ONE);
            default: return DATA_W'($urandom_range(0, 1 << 20));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_block();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DATA_W'(MAX_BLOCK_DEF);
            2:       return $urandom();
            3:       return DATA_W'($urandom_range(9, 40));
            default: return DATA_W'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic send_frame(input sample_req_t s);
        mix_req_t m;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        predict_mix(s, m);
        expected_mix.push_back(m);
        frames_sent++;
    endtask

    task automatic send_random(input int n);
        repeat (n)
            send_frame(frame_of(rand_sample(), rand_sample()));
    endtask

    task automatic wait_for_mixes();
        sample_valid <= 1'b0;
        while (expected_mix.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [DATA_W-1:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        apply_setting(idx, v);
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // defaults: both sources off, 256-frame block, then block cut short
    task automatic test_reset_defaults();
        send_frame(frame_of(SMP_MAX, SMP_MAX));
        send_frame(frame_of(SMP_MIN, SMP_MIN));
        wait_for_mixes();
        cfg_write(REG_BLOCK_FRAMES, 32'd0);
        send_frame(frame_of(SMP_MAX, SMP_MIN));
        wait_for_mixes();
    endtask

    task automatic test_saturation();
        cfg_write(REG_INS_EN, 32'd1);
        cfg_write(REG_VOC_EN, 32'hFFFF_FFFF);
        cfg_write(REG_INS_GAIN, 32'hFFFF_FFFF);
        cfg_write(REG_VOC_GAIN, 32'h0010_0001);
        cfg_write(REG_BLOCK_FRAMES, 32'd1);
        send_frame(frame_of(SMP_MAX, SMP_MAX));
        send_frame(frame_of(SMP_MIN, SMP_MIN));
        send_frame(frame_of(SMP_MAX, SMP_MIN));
        send_frame(frame_of('0, '0));
        wait_for_mixes();
    endtask

    // half gain on instrument, voice gain masked to zero: rounding ties
    task automatic test_rounding();
        cfg_write(REG_INS_GAIN, 32'h0000_8000);
        cfg_write(REG_VOC_GAIN, 32'h0020_0000);
        cfg_write(REG_BLOCK_FRAMES, 32'h0000_2001);
        send_frame(frame_of(SAMPLE_BITS'(1), SMP_MAX));
        send_frame(frame_of({SAMPLE_BITS{1'b1}}, SMP_MAX));
        send_frame(frame_of(SAMPLE_BITS'(3), '0));
        send_frame(frame_of(-SAMPLE_BITS'(3), '0));
        wait_for_mixes();
    endtask

    // longest block, then cut short mid-block
    task automatic test_block_limits();
        cfg_write(REG_INS_EN, 32'hFFFF_FFFE);
        cfg_write(REG_VOC_GAIN, 32'h0010_0000);
        cfg_write(REG_BLOCK_FRAMES, 32'h0000_1FFF);
        send_random(3);
        wait_for_mixes();
        cfg_write(REG_BLOCK_FRAMES, 32'd3);
        send_random(1);
        wait_for_mixes();
    endtask

    // block stretched mid-way so both ramps run past 16.0 and below zero
    task automatic test_ramp_overshoot();
        cfg_write(REG_INS_EN, 32'd1);
        cfg_write(REG_INS_GAIN, DATA_W'(GAIN_MAX));
        cfg_write(REG_VOC_GAIN, 32'd0);
        cfg_write(REG_BLOCK_FRAMES, 32'd4);
        send_random(2);
        wait_for_mixes();
        cfg_write(REG_BLOCK_FRAMES, 32'd64);
        cfg_write(REG_VOC_GAIN, DATA_W'(GAIN_MAX));
        send_random(4);
        wait_for_mixes();
        cfg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
        cfg_write(REG_SPARE_HI, 32'h0000_0000);
        cfg_write(REG_BLOCK_FRAMES, 32'd1);
        send_random(1);
        wait_for_mixes();
    endtask

    task automatic test_random_phases();
        int n;
        while (random_sent < RANDOM_FRAMES)
        begin
            if (random_sent >= RANDOM_FRAMES - QUIET_FRAMES)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            cfg_write(REG_INS_EN, $urandom());
            cfg_write(REG_VOC_EN, $urandom());
            cfg_write(REG_INS_GAIN, rand_gain());
            cfg_write(REG_VOC_GAIN, rand_gain());
            cfg_write(REG_BLOCK_FRAMES, rand_block());
            if ($urandom_range(0, 7) == 0)
                cfg_write(3'(REG_SPARE_LO + $urandom_range(0, 2)), $urandom());
            n = $urandom_range(4, 30);
            send_random(n);
            random_sent += n;
            wait_for_mixes();
            if ($urandom_range(0, 2) == 0)
            begin
                // mid-block rewrite
                cfg_write(REG_BLOCK_FRAMES, rand_block());
                cfg_write(REG_INS_GAIN, rand_gain());
                n = $urandom_range(2, 12);
                send_random(n);
                random_sent += n;
                wait_for_mixes();
            end
        end
    endtask

    initial
    begin
        src_enable     = '{default: 1'b0};
        gain_setting   = '{default: longint'(GAIN_ONE)};
        settled_gain   = '{default: 0};
        ramp_gain      = '{default: 0};
        ramp_step      = '{default: 0};
        block_target   = '{default: 0};
        frames_setting = int'(BF_RESET);
        frame_pos      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_saturation();
        test_rounding();
        test_block_limits();
        test_ramp_overshoot();
        test_random_phases();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_mix.size() != 0)
            report_mismatch($sformatf("%0d mix requests never arrived", expected_mix.size()));
        $display("Sent %0d sample requests and %0d register writes; checked %0d mix requests",
                 frames_sent, reg_writes, mixes_checked);
        $display("Saw %0d block ends; %0d mismatches", block_ends, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && mix_valid && mix_ready)
        begin
            if (expected_mix.size() == 0)
                report_mismatch("mix request with nothing expected");
            else
            begin
                oldest_mix = expected_mix.pop_front();
                mixes_checked++;
                if (oldest_mix.block_end)
                    block_ends++;
                if (mix_data.left_sample !== oldest_mix.left_sample
                    || mix_data.right_sample !== oldest_mix.right_sample
                    || mix_data.block_end !== oldest_mix.block_end)
                    report_mismatch($sformatf(
                        "mix %0d: got L=%h R=%h end=%b, want L=%h R=%h end=%b",
                        mixes_checked, mix_data.left_sample, mix_data.right_sample,
                        mix_data.block_end, oldest_mix.left_sample,
                        oldest_mix.right_sample, oldest_mix.block_end));
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            mix_ready <= (stall_left == 0);
        end
        else if (idle_on && mix_ready && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 17);
            mix_ready <= 1'b0;
        end
        else
            mix_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (mix_valid && mix_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no request moved for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
